// ===== sv/cct_pkg.sv =====
// Shared types and constants of the columnar transposition cipher.
// Used by the controller, the datapath and the top level; no dependencies.
package cct_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 16;
    localparam int COL_W       = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SYM_W-1:0] SPACE_SYMBOL = 16'h0020;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV,
        ST_SIZE,
        ST_ARM,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_run;
        logic size;
        logic arm;
        logic scan_run;
        logic emit_run;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic msg_end;
        logic div_done;
        logic need_scan;
        logic scan_done;
        logic emit_done;
    } status_t;

endpackage

// ===== sv/cct_ctrl.sv =====
// Sequencing state machine of the columnar transposition cipher.
// Depends on cct_pkg (state_t, cmd_t, status_t).
module cct_ctrl
    import cct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t sts,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (sts.msg_end)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                state_next = ST_ARM;
            end
            ST_ARM:
            begin
                state_next = sts.need_scan ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.emit_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD: cmd.load     = 1'b1;
            ST_DIV:  cmd.div_run  = 1'b1;
            ST_SIZE: cmd.size     = 1'b1;
            ST_ARM:  cmd.arm      = 1'b1;
            ST_SCAN: cmd.scan_run = 1'b1;
            ST_EMIT: cmd.emit_run = 1'b1;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== sv/cct_datapath.sv =====
// Datapath of the columnar transposition cipher: config registers, symbol buffer,
// grid divider, address walker, trailing-space scan and registered output stage.
// Depends on cct_pkg; sequenced by cct_ctrl.
module cct_datapath
    import cct_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COL_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic [SYM_W-1:0]     s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [SYM_W-1:0]     m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser,
    input  cmd_t                 cmd,
    output status_t              sts
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int KW  = CW + 1;
    localparam int DCW = $clog2(CW + 1);

    localparam logic [CW-1:0]    MAX_C = CW'(MAX_LEN);
    localparam logic [KW-1:0]    MAX_K = KW'(MAX_LEN);
    localparam logic [COL_W-1:0] MAX_7 = COL_W'(MAX_LEN);

    // configuration
    logic [COL_W-1:0] columns_reg;
    logic             decrypt_reg;
    logic [CW-1:0]    c_eff;

    // loading
    logic [SYM_W-1:0] buf_mem [MAX_LEN];
    logic [CW-1:0]    cnt_reg;
    logic             drop_reg;
    logic             accept;
    logic             msg_end;
    logic             full_buf;
    logic [CW-1:0]    n_end;

    // per-message parameters
    logic [CW-1:0]    n_reg;
    logic [CW-1:0]    c_reg;
    logic             mode_reg;
    logic             dflag_reg;

    // divider
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    quo_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [CW:0]      rem_sh;
    logic [CW:0]      rem_diff;
    logic             rem_ge;

    // grid size
    logic [CW-1:0]    rows_reg;
    logic [KW-1:0]    total_reg;
    logic [CW-1:0]    rows_c;
    logic [2*CW-1:0]  prod;
    logic             need_scan;
    logic             grid_ovf;
    logic [CW-1:0]    rows_m1;
    logic [CW-1:0]    c_m1;
    logic [KW-1:0]    total_m1;

    // emission bookkeeping
    logic [CW-1:0]    limit_reg;
    logic [CW-1:0]    iss_reg;
    logic             ovf_reg;
    logic             trim_reg;
    logic [CW-1:0]    keep_reg;
    logic [CW-1:0]    off_reg;

    // address walker (grid row/column and buffer address)
    logic [AW-1:0]    wcol_reg;
    logic [AW-1:0]    wcol_next;
    logic [AW-1:0]    wrow_reg;
    logic [AW-1:0]    wrow_next;
    logic [KW-1:0]    waddr_reg;
    logic [KW-1:0]    waddr_next;

    // trailing-space scan
    logic [AW-1:0]    sc_p_reg;
    logic             sc_exh_reg;
    logic             sc_vld_reg;
    logic [AW-1:0]    sc_tag_reg;
    logic             sc_eval;
    logic             sc_hit;
    logic             sc_zero;
    logic             scan_done;
    logic             scan_issue;
    logic [CW-1:0]    keep_val;
    logic [CW-1:0]    left_val;

    // read and output stages
    logic             rd_vld_reg;
    logic [SYM_W-1:0] rd_data_reg;
    logic             rd_pad_reg;
    logic             rd_last_reg;
    logic             rd_ovf_reg;
    logic             out_vld_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic             out_last_reg;
    logic             out_ovf_reg;
    logic             adv2;
    logic             move;
    logic             space;
    logic             emit_issue;
    logic             in_plain;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    emit_addr;
    logic             emit_pad;
    logic [CW-1:0]    iss_inc;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COL_W'(1);
            decrypt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMNS: columns_reg <= cfg_wdata;
                CFG_DECRYPT: decrypt_reg <= cfg_wdata[0];
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    always_comb
    begin
        if (columns_reg == '0)
        begin
            c_eff = CW'(1);
        end
        else if (columns_reg > MAX_7)
        begin
            c_eff = MAX_C;
        end
        else
        begin
            c_eff = columns_reg[CW-1:0];
        end
    end

    // ---------------- loading ----------------
    assign accept   = cmd.load & s_tvalid;
    assign msg_end  = accept & s_tlast;
    assign full_buf = (cnt_reg == MAX_C);
    assign n_end    = full_buf ? cnt_reg : cnt_reg + CW'(1);

    always_ff @(posedge clk)
    begin
        if (accept && !full_buf)
        begin
            buf_mem[cnt_reg[AW-1:0]] <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (msg_end)
        begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (full_buf)
            begin
                drop_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
    end

    // ---------------- divider: n / c, one quotient bit per cycle ----------------
    assign rem_sh   = {rem_reg, quo_reg[CW-1]};
    assign rem_ge   = (rem_sh >= {1'b0, c_reg});
    assign rem_diff = rem_sh - {1'b0, c_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (msg_end)
        begin
            div_cnt_reg <= DCW'(CW);
        end
        else if (cmd.div_run && div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg_end)
        begin
            n_reg     <= n_end;
            c_reg     <= c_eff;
            mode_reg  <= decrypt_reg;
            dflag_reg <= drop_reg | full_buf;
            rem_reg   <= '0;
            quo_reg   <= n_end;
        end
        else if (cmd.div_run && div_cnt_reg != '0)
        begin
            rem_reg <= rem_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
            quo_reg <= {quo_reg[CW-2:0], rem_ge};
        end
    end

    // ---------------- grid size ----------------
    // encrypt rounds the row count up, decrypt rounds it down
    assign rows_c = mode_reg ? quo_reg : quo_reg + CW'(rem_reg != '0);
    assign prod   = rows_c * c_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.size)
        begin
            rows_reg  <= rows_c;
            total_reg <= prod[KW-1:0];
        end
    end

    assign need_scan = mode_reg & (rows_reg != '0);
    assign grid_ovf  = ~mode_reg & (total_reg > MAX_K);
    assign rows_m1   = rows_reg - CW'(1);
    assign c_m1      = c_reg - CW'(1);
    assign total_m1  = total_reg - KW'(1);

    // ---------------- trailing-space scan ----------------
    assign sc_eval   = cmd.scan_run & sc_vld_reg;
    assign sc_hit    = sc_eval & (rd_data_reg != SPACE_SYMBOL);
    assign sc_zero   = sc_eval & (rd_data_reg == SPACE_SYMBOL) & (sc_tag_reg == '0);
    assign scan_done = sc_hit | sc_zero;
    assign keep_val  = sc_hit ? CW'(sc_tag_reg) + CW'(1) : '0;
    assign left_val  = n_reg - total_reg[CW-1:0];

    assign scan_issue = cmd.scan_run & ~rd_vld_reg & ~sc_exh_reg & ~scan_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_vld_reg <= 1'b0;
            sc_exh_reg <= 1'b0;
        end
        else
        begin
            sc_vld_reg <= scan_issue;
            if (cmd.arm)
            begin
                sc_exh_reg <= 1'b0;
            end
            else if (scan_issue && sc_p_reg == '0)
            begin
                sc_exh_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arm)
        begin
            sc_p_reg <= total_m1[AW-1:0];
        end
        else if (scan_issue)
        begin
            sc_p_reg   <= sc_p_reg - AW'(1);
            sc_tag_reg <= sc_p_reg;
        end
    end

    // ---------------- emission control ----------------
    assign adv2       = ~out_vld_reg | m_tready;
    assign move       = rd_vld_reg & adv2;
    assign space      = ~rd_vld_reg | adv2;
    assign emit_issue = cmd.emit_run & (iss_reg != limit_reg) & space;
    assign in_plain   = trim_reg & (iss_reg < keep_reg);
    assign iss_inc    = iss_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg   <= '0;
            limit_reg <= '0;
        end
        else if (cmd.arm)
        begin
            iss_reg <= '0;
            if (mode_reg)
            begin
                limit_reg <= n_reg;
            end
            else
            begin
                limit_reg <= (total_reg > MAX_K) ? MAX_C : total_reg[CW-1:0];
            end
        end
        else if (scan_done)
        begin
            limit_reg <= keep_val + left_val;
        end
        else if (emit_issue)
        begin
            iss_reg <= iss_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arm)
        begin
            ovf_reg  <= dflag_reg | grid_ovf;
            trim_reg <= need_scan;
        end
        if (scan_done)
        begin
            keep_reg <= keep_val;
            off_reg  <= total_reg[CW-1:0] - keep_val;
        end
    end

    // emission source: column readout, plain passthrough, scattered rows, leftover tail
    always_comb
    begin
        emit_pad  = 1'b0;
        emit_addr = iss_reg[AW-1:0];
        if (!mode_reg)
        begin
            emit_addr = waddr_reg[AW-1:0];
            emit_pad  = (waddr_reg >= KW'(n_reg));
        end
        else if (in_plain)
        begin
            emit_addr = waddr_reg[AW-1:0];
        end
        else if (trim_reg)
        begin
            emit_addr = AW'(iss_reg + off_reg);
        end
    end

    assign rd_addr = cmd.scan_run ? waddr_reg[AW-1:0] : emit_addr;

    // walker: grid position (row, column) and the buffer address it maps to
    always_comb
    begin
        wcol_next  = wcol_reg;
        wrow_next  = wrow_reg;
        waddr_next = waddr_reg;
        if (cmd.arm)
        begin
            if (need_scan)
            begin
                wcol_next  = c_m1[AW-1:0];
                wrow_next  = rows_m1[AW-1:0];
                waddr_next = total_m1;
            end
            else
            begin
                wcol_next  = '0;
                wrow_next  = '0;
                waddr_next = '0;
            end
        end
        else if (scan_done)
        begin
            wcol_next  = '0;
            wrow_next  = '0;
            waddr_next = '0;
        end
        else if (scan_issue)
        begin
            // step backward through plaintext order
            if (wcol_reg == '0)
            begin
                wcol_next  = c_m1[AW-1:0];
                wrow_next  = wrow_reg - AW'(1);
                waddr_next = total_reg - KW'(rows_reg) + KW'(wrow_reg) - KW'(1);
            end
            else
            begin
                wcol_next  = wcol_reg - AW'(1);
                waddr_next = waddr_reg - KW'(rows_reg);
            end
        end
        else if (emit_issue && !mode_reg)
        begin
            // column readout of the row-wise grid
            if (wrow_reg == rows_m1[AW-1:0])
            begin
                wrow_next  = '0;
                wcol_next  = wcol_reg + AW'(1);
                waddr_next = KW'(wcol_reg) + KW'(1);
            end
            else
            begin
                wrow_next  = wrow_reg + AW'(1);
                waddr_next = waddr_reg + KW'(c_reg);
            end
        end
        else if (emit_issue && in_plain)
        begin
            // forward plaintext order, buffer holds the grid column by column
            if (wcol_reg == c_m1[AW-1:0])
            begin
                wcol_next  = '0;
                wrow_next  = wrow_reg + AW'(1);
                waddr_next = KW'(wrow_reg) + KW'(1);
            end
            else
            begin
                wcol_next  = wcol_reg + AW'(1);
                waddr_next = waddr_reg + KW'(rows_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wcol_reg  <= wcol_next;
        wrow_reg  <= wrow_next;
        waddr_reg <= waddr_next;
    end

    // ---------------- buffer read and output stages ----------------
    always_ff @(posedge clk)
    begin
        if (emit_issue || scan_issue)
        begin
            rd_data_reg <= buf_mem[rd_addr];
        end
        if (emit_issue)
        begin
            rd_pad_reg  <= emit_pad;
            rd_last_reg <= (iss_inc == limit_reg);
            rd_ovf_reg  <= ovf_reg;
        end
        if (move)
        begin
            out_sym_reg  <= rd_pad_reg ? SPACE_SYMBOL : rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_ovf_reg  <= rd_ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (emit_issue)
            begin
                rd_vld_reg <= 1'b1;
            end
            else if (move)
            begin
                rd_vld_reg <= 1'b0;
            end
            if (move)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    assign sts.msg_end   = msg_end;
    assign sts.div_done  = (div_cnt_reg == '0);
    assign sts.need_scan = need_scan;
    assign sts.scan_done = scan_done;
    assign sts.emit_done = (iss_reg == limit_reg);

endmodule

// ===== sv/columnar_transposition_cipher.sv =====
// Columnar transposition cipher over 16-bit symbols. A message streams in at one
// symbol per cycle (s_tready high) until the transaction with s_tlast; symbols past
// MAX_LEN are dropped and flagged in m_tuser. After the last symbol the block takes
// no input while a bit-serial divider sizes the grid and the readout is set up;
// decrypt then scans the grid backward for trailing spaces, at most one grid
// position per cycle. Results leave through a registered output stage at one per
// cycle while m_tready is high, the rate of the single buffer read port; input
// reopens once the last result read has been issued and the controller is back in
// its load state.
module columnar_transposition_cipher
    import cct_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COL_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SYM_W-1:0]     s_tdata,    // [15:0] symbol
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SYM_W-1:0]     m_tdata,    // [15:0] out_symbol
    output logic                 m_tlast,
    output logic                 m_tuser     // [0] overflow
);

    cmd_t    cmd;
    status_t sts;

    cct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cct_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    assign s_tready = cmd.load;

endmodule

// ===== sv/cct_checker.sv =====
// Port-level checks for the columnar transposition cipher, bound to the top level.
// Depends on cct_pkg for field widths.
module cct_checker
    import cct_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tlast,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [SYM_W-1:0] m_tdata,
    input logic             m_tlast,
    input logic             m_tuser
);

    logic run_reg;
    logic run_user_reg;

    // inside a result run once a non-last transaction has gone out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            run_user_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            run_reg      <= ~m_tlast;
            run_user_reg <= m_tuser;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output transaction changed while stalled");

    a_ovf_per_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && run_reg) |-> (m_tuser == run_user_reg))
        else $error("overflow flag changed within a result run");

    a_load_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!s_tready ##1 !s_tready))
        else $error("input accepted while the grid is being sized");

endmodule

bind columnar_transposition_cipher cct_checker u_cct_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== dv/columnar_transposition_cipher_tb.sv =====
// Testbench for columnar_transposition_cipher: directed and random messages in both modes,
// checked against an in-bench transposition predictor. Depends on cct_pkg and the top level.
`timescale 1ns / 1ps

module columnar_transposition_cipher_tb;
    import cct_pkg::*;

    localparam int DEPTH        = MAX_LEN_DEF;
    localparam int ITEM_TARGET  = 270;
    localparam int QUIET_CYCLES = 100;   // divider + worst backward scan + output stage
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             overflow;
    } cipher_out_t;

    // Predicts the result run of each message and checks results in order.
    class cipher_scoreboard;
        logic [COL_W-1:0] key_columns;
        logic             decrypt;
        logic [SYM_W-1:0] msg_buf [DEPTH];
        int               msg_len;
        bit               msg_dropped;
        cipher_out_t      expected_q [$];
        int               errors;

        function new();
            key_columns = COL_W'(1);
            decrypt     = 1'b0;
            msg_len     = 0;
            msg_dropped = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_symbol(logic [SYM_W-1:0] sym, logic is_last);
            logic [SYM_W-1:0] plain [DEPTH];
            logic [SYM_W-1:0] out_syms [$];
            cipher_out_t      item;
            int               n, c, rows, full, keep, idx, i, j;
            bit               ovf;
            if (msg_len < DEPTH)
            begin
                msg_buf[msg_len] = sym;
                msg_len++;
            end
            else
                msg_dropped = 1'b1;
            if (!is_last)
                return;
            n   = msg_len;
            c   = (key_columns == 0) ? 1 : (key_columns > DEPTH) ? DEPTH : int'(key_columns);
            ovf = msg_dropped;
            if (!decrypt)
            begin
                rows = (n + c - 1) / c;
                if (rows * c > DEPTH)
                    ovf = 1'b1;
                for (i = 0; i < c; i++)
                    for (j = 0; j < rows; j++)
                        if (out_syms.size() < DEPTH)
                            out_syms = {out_syms,
                                        (i + j * c < n) ? msg_buf[i + j * c] : SPACE_SYMBOL};
            end
            else
            begin
                // rows == 0 leaves full at zero: short input passes straight through
                rows = n / c;
                full = rows * c;
                idx  = 0;
                for (i = 0; i < c; i++)
                    for (j = 0; j < rows; j++)
                    begin
                        plain[i + j * c] = msg_buf[idx];
                        idx++;
                    end
                keep = full;
                while (keep > 0 && plain[keep - 1] == SPACE_SYMBOL)
                    keep--;
                for (i = 0; i < keep; i++)
                    out_syms = {out_syms, plain[i]};
                for (i = full; i < n; i++)
                    out_syms = {out_syms, msg_buf[i]};
            end
            for (i = 0; i < out_syms.size(); i++)
            begin
                item.symbol   = out_syms[i];
                item.last     = (i == out_syms.size() - 1);
                item.overflow = ovf;
                expected_q    = {expected_q, item};
            end
            msg_len     = 0;
            msg_dropped = 1'b0;
        endfunction

        function void check_symbol(logic [SYM_W-1:0] sym, logic is_last, logic ovf);
            cipher_out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result symbol %h last %b overflow %b",
                             $realtime, sym, is_last, ovf);
                return;
            end
            want = expected_q.pop_front();
            if (sym !== want.symbol || is_last !== want.last || ovf !== want.overflow)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result mismatch, expected %h/%b/%b got %h/%b/%b",
                             $realtime, want.symbol, want.last, want.overflow,
                             sym, is_last, ovf);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COL_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SYM_W-1:0]     s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [SYM_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    cipher_scoreboard sb;
    logic [SYM_W-1:0] msg_q [$];
    int               items_sent;
    int               rx_hold;
    bit               tx_throttle;
    bit               rx_throttle;

    columnar_transposition_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap(bit throttled);
        int r;
        if (!throttled)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 19)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic program_key(input logic [COL_W-1:0] cols, input logic dec);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        // a message may have produced nothing yet still be scanning
        repeat (QUIET_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_wdata <= cols;
        @(negedge clk);
        cfg_index <= CFG_DECRYPT;
        cfg_wdata <= {{(COL_W-1){1'b0}}, dec};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.key_columns = cols;
        sb.decrypt     = dec;
    endtask

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic is_last);
        int gap;
        gap = pick_gap(tx_throttle);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_symbol(sym, is_last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_message();
        int i;
        for (i = 0; i < msg_q.size(); i++)
            send_symbol(msg_q[i], i == msg_q.size() - 1);
    endtask

    // Receiver: random stalls, plus a long hold-off requested by the stimulus.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = pick_gap(rx_throttle);
            end
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_symbol(m_tdata, m_tlast, m_tuser);

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int               phase, len, eff_c, k;
        logic [COL_W-1:0] cols;
        logic             dec;
        bit               long_msg;
        sb          = new();
        items_sent  = 0;
        rx_hold     = 0;
        tx_throttle = 1'b1;
        rx_throttle = 1'b1;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_COLUMNS;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // padding of a partial last row, extreme symbol values
        program_key(COL_W'(3), 1'b0);
        msg_q = {16'h0000, 16'hFFFF, 16'h0041, 16'h0042, 16'h0043, 16'h5555, 16'hAAAA};
        send_message();
        // zero columns behave as one
        program_key(COL_W'(0), 1'b0);
        msg_q = {16'h1234};
        send_message();
        // column count above depth saturates, single padded row
        program_key(COL_W'(127), 1'b0);
        msg_q = {16'h0061, 16'h0062, 16'h0063};
        send_message();
        // decrypt input shorter than a row passes through
        program_key(COL_W'(5), 1'b1);
        msg_q = {16'h0031, 16'h0032};
        send_message();
        // trailing spaces trimmed, leftover row kept, all-space grid yields nothing
        program_key(COL_W'(2), 1'b1);
        msg_q = {16'h0041, SPACE_SYMBOL, SPACE_SYMBOL, SPACE_SYMBOL, SPACE_SYMBOL};
        send_message();
        msg_q = {SPACE_SYMBOL, SPACE_SYMBOL};
        send_message();
        msg_q = {16'h0120, SPACE_SYMBOL};
        send_message();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       cols = COL_W'(0);
                1:       cols = COL_W'(1);
                2:       cols = COL_W'(64);
                3:       cols = COL_W'($urandom_range(65, 127));
                default: cols = COL_W'($urandom_range(2, 12));
            endcase
            dec = 1'($urandom_range(0, 1));
            if (phase == 2)
            begin
                // long message: may bring dropped symbols and a cut readout together
                cols = COL_W'(7);
                dec  = 1'b0;
            end
            program_key(cols, dec);
            eff_c       = (cols == 0) ? 1 : (cols > DEPTH) ? DEPTH : int'(cols);
            tx_throttle = ($urandom_range(0, 3) != 0);
            rx_throttle = ($urandom_range(0, 3) != 0);
            if (phase == 1)
            begin
                // receiver backs up while the sender keeps offering
                tx_throttle = 1'b0;
                rx_hold     = HOLD_CYCLES;
            end
            long_msg = (phase == 2);
            repeat ($urandom_range(2, 4))
            begin
                if (long_msg || $urandom_range(0, 15) == 0)
                    len = $urandom_range(60, 72);
                else if (dec && eff_c <= 16 && $urandom_range(0, 1) == 1)
                    len = eff_c * $urandom_range(1, 4) + (($urandom_range(0, 3) == 0) ? 1 : 0);
                else
                    len = $urandom_range(1, 16);
                long_msg = 1'b0;
                msg_q.delete();
                for (k = 0; k < len; k++)
                    msg_q = {msg_q,
                             ($urandom_range(0, 3) == 0) ? SPACE_SYMBOL : SYM_W'($urandom)};
                send_message();
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
